FILE: hw/rtl/ptf_pkg.sv
package ptf_pkg;

  // request kinds carried on the input tuser
  localparam logic [1:0] REQ_GROUP  = 2'd0;
  localparam logic [1:0] REQ_COEF   = 2'd1;
  localparam logic [1:0] REQ_SAMPLE = 2'd2;

  localparam int REQ_W      = 2;
  localparam int INDEX_W    = 9;
  localparam int VALUE_W    = 9;
  localparam int SAMPLE_W   = 16;
  localparam int IN_DATA_W  = 40;   // 34 payload bits padded to whole bytes
  localparam int OUT_W      = 40;
  localparam int CFG_W      = 5;
  localparam int GSIZE_W    = 8;

  localparam int HIST_DEPTH = 256;
  localparam int HIST_AW    = 8;

  // coefficient word: sign on top, delay below
  localparam int COEF_W     = 9;
  localparam int SIGN_BIT   = 8;
  localparam int DELAY_W    = 8;

  localparam int SAMPLE_SHIFT = 16;

  localparam logic [CFG_W-1:0] GROUP_COUNT_RST = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GROUP,
    ST_WALK,
    ST_FINAL,
    ST_DONE
  } ptf_state_e;

endpackage

FILE: hw/rtl/power_of_two_term_fir_filter_unit.sv
// Channel   Dir  Payload (low bit first)                        Beat when
// s_axis    in   tuser: req_type[1:0]                            tvalid & tready
//                tdata: entry_index[8:0], entry_value[17:9],
//                       sample[33:18], zero pad[39:34]
// m_axis    out  tdata: filtered[39:0]                           tvalid & tready
// cfg       in   cfg_data_i: group_count[4:0]                    cfg_valid_i & cfg_ready_o
//
// Table-write and ignored beats are taken in ST_IDLE and leave it there. A
// sample beat walks its groups through the single shared add/sub accumulator,
// fed through a read pipe (coefficient RAM, then history RAM). Each group
// drains that pipe before the next halving. Reset clears the history through
// per-entry valid bits, so no clearing pass is needed. A result waiting on
// m_axis stalls only the ST_DONE step of the next sample.
module power_of_two_term_fir_filter_unit #(
  parameter int COEF_DEPTH = 512,
  parameter int NUM_GROUPS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [ptf_pkg::IN_DATA_W-1:0] s_axis_tdata,  // entry_index, entry_value, sample, pad
  input  logic [ptf_pkg::REQ_W-1:0]   s_axis_tuser,    // req_type
  // result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [ptf_pkg::OUT_W-1:0]   m_axis_tdata,    // filtered
  // config write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [ptf_pkg::CFG_W-1:0]   cfg_data_i
);

  import ptf_pkg::*;

  localparam int CAW   = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
  localparam int GW    = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int GCW   = $clog2(NUM_GROUPS + 1);
  localparam int PW    = $clog2(NUM_GROUPS * 255 + 1);
  // |sum| <= COEF_DEPTH * 2^31, plus sign and headroom
  localparam int ACC_W = (CAW + 34 > OUT_W + 1) ? CAW + 34 : OUT_W + 1;

  // input fields
  logic [REQ_W-1:0]    req_type;
  logic [INDEX_W-1:0]  entry_index;
  logic [VALUE_W-1:0]  entry_value;
  logic [SAMPLE_W-1:0] sample;

  assign req_type    = s_axis_tuser;
  assign entry_index = s_axis_tdata[INDEX_W-1:0];
  assign entry_value = s_axis_tdata[INDEX_W+VALUE_W-1:INDEX_W];
  assign sample      = s_axis_tdata[INDEX_W+VALUE_W+SAMPLE_W-1:INDEX_W+VALUE_W];

  ptf_state_e state_q, state_d;

  logic              in_beat;
  logic              start;
  logic [CFG_W-1:0]  cfg_q;
  logic [GCW-1:0]    group_lim;
  logic [GCW-1:0]    groups_q;
  logic [GCW-1:0]    g_q;
  logic [GSIZE_W-1:0] group_sizes_q [NUM_GROUPS];
  logic [GSIZE_W-1:0] size_cur;
  logic [GSIZE_W-1:0] k_q;
  logic [PW-1:0]     pos_q;
  logic [HIST_AW-1:0] hp_q;
  logic [HIST_DEPTH-1:0] hist_vld_q;

  logic              p1_vld_q, p1_in_q;
  logic              p2_vld_q, p2_sign_q, p2_hv_q;

  logic signed [ACC_W-1:0] acc_q;
  logic signed [ACC_W-1:0] term;

  logic              out_vld_q;
  logic [OUT_W-1:0]  out_data_q;

  // control strobes
  logic issue, halve, group_end, last_group, load_out;

  logic [COEF_W-1:0]   coef_rdata;
  logic [SAMPLE_W-1:0] hist_rdata;
  logic [HIST_AW-1:0]  hist_raddr;

  assign in_beat = s_axis_tvalid && s_axis_tready;
  assign start   = in_beat && (req_type == REQ_SAMPLE);

  // saturate group count to the table size
  assign group_lim = (32'(cfg_q) > NUM_GROUPS) ? GCW'(NUM_GROUPS) : GCW'(cfg_q);

  assign size_cur   = group_sizes_q[g_q[GW-1:0]];
  assign last_group = (g_q + GCW'(1)) == groups_q;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          state_d = (group_lim == '0) ? ST_FINAL : ST_GROUP;
        end
      end
      ST_GROUP: state_d = ST_WALK;
      ST_WALK: begin
        if (group_end) begin
          state_d = last_group ? ST_FINAL : ST_GROUP;
        end
      end
      ST_FINAL: state_d = ST_DONE;
      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    issue     = 1'b0;
    halve     = 1'b0;
    group_end = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      ST_GROUP: halve = 1'b1;
      ST_WALK: begin
        issue     = (k_q != size_cur);
        // group done once every term has left the read pipe
        group_end = (k_q == size_cur) && !p1_vld_q && !p2_vld_q;
      end
      ST_FINAL: halve = 1'b1;
      ST_DONE:  load_out = !out_vld_q || m_axis_tready;
      default: ;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // ---------------------------------------------------------------- memories
  ptf_ram #(
    .WIDTH (COEF_W),
    .DEPTH (COEF_DEPTH)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (in_beat && (req_type == REQ_COEF) && (32'(entry_index) < COEF_DEPTH)),
    .waddr_i (CAW'(entry_index)),
    .wdata_i (entry_value),
    .raddr_i (CAW'(pos_q)),
    .rdata_o (coef_rdata)
  );

  // delayed tap: pointer minus delay, wrapping in the history
  assign hist_raddr = hp_q - coef_rdata[DELAY_W-1:0];

  ptf_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (HIST_DEPTH)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (start),
    .waddr_i (hp_q),
    .wdata_i (sample),
    .raddr_i (hist_raddr),
    .rdata_o (hist_rdata)
  );

  // sample sign-extended and placed at bit 16
  assign term = {{(ACC_W-SAMPLE_W-SAMPLE_SHIFT){hist_rdata[SAMPLE_W-1]}},
                 hist_rdata, {SAMPLE_SHIFT{1'b0}}};

  // ---------------------------------------------------------------- control regs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cfg_q      <= GROUP_COUNT_RST;
      hp_q       <= '0;
      hist_vld_q <= '0;
      p1_vld_q   <= 1'b0;
      p2_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      p1_vld_q <= issue;
      p2_vld_q <= p1_vld_q && p1_in_q;
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_q <= cfg_data_i;
      end
      if (start) begin
        hist_vld_q[hp_q] <= 1'b1;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
        hp_q      <= hp_q + HIST_AW'(1);
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- datapath regs
  always_ff @(posedge clk_i) begin
    if (in_beat && (req_type == REQ_GROUP) && (32'(entry_index) < NUM_GROUPS)) begin
      group_sizes_q[GW'(entry_index)] <= entry_value[GSIZE_W-1:0];
    end

    if (start) begin
      groups_q <= group_lim;
      g_q      <= '0;
      pos_q    <= '0;
    end else if (group_end) begin
      g_q <= g_q + GCW'(1);
    end else if (issue) begin
      pos_q <= pos_q + PW'(1);
    end

    if (halve) begin
      k_q <= '0;
    end else if (issue) begin
      k_q <= k_q + GSIZE_W'(1);
    end

    // stage 1: coefficient read issued; positions past the table are dropped
    p1_in_q <= (32'(pos_q) < COEF_DEPTH);

    // stage 2: history read issued from the coefficient word
    p2_sign_q <= coef_rdata[SIGN_BIT];
    p2_hv_q   <= hist_vld_q[hist_raddr];

    // shared accumulator: clear, halve or add/sub one term
    if (start) begin
      acc_q <= '0;
    end else if (halve) begin
      acc_q <= acc_q >>> 1;
    end else if (p2_vld_q && p2_hv_q) begin
      acc_q <= p2_sign_q ? (acc_q - term) : (acc_q + term);
    end

    if (load_out) begin
      out_data_q <= acc_q[OUT_W-1:0];
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: hw/rtl/ptf_ram.sv
module ptf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ptf_pkg::*;

  // Table sizes of the instance under test (defaults of the block)
  localparam int COEF_DEPTH = 512;
  localparam int NUM_GROUPS = 16;
  localparam int GIDX_W     = $clog2(NUM_GROUPS);
  localparam int CIDX_W     = $clog2(COEF_DEPTH);

  // Request kind the block drops without a trace
  localparam logic [1:0] REQ_NONE = 2'd3;

  localparam int N_DIR          = 21;
  localparam int N_PHASE        = 8;
  localparam int PHASE_ITEMS    = 64;
  localparam int TAIL_CYCLES    = 64;
  localparam int CFG_HOLD       = 8;
  // Longest quiet stretch: a 16 x 255 walk, plus stalls
  localparam int WATCHDOG_LIMIT = 20000;

  typedef enum int {RX_FREE, RX_CHOPPY, RX_LONG} rx_mode_e;

  typedef struct packed {
    logic [1:0]        req;
    logic [8:0]        idx;
    logic [8:0]        val;
    logic [15:0]       smp;
    bit                typed;   // want holds a hand-computed result
    logic [OUT_W-1:0]  want;
  } dir_row_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata  = '0;  // entry_index, entry_value, sample, pad
  logic [REQ_W-1:0]       s_axis_tuser  = '0;  // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_W-1:0]       m_axis_tdata;        // filtered
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_W-1:0]       cfg_data_i    = '0;  // group_count

  always #6 clk_i = ~clk_i;

  power_of_two_term_fir_filter_unit #(
    .COEF_DEPTH(COEF_DEPTH),
    .NUM_GROUPS(NUM_GROUPS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Filter shadow: history, tables and group count as the block should hold them
  // ---------------------------------------------------------------------------
  logic [SAMPLE_W-1:0] history [HIST_DEPTH];
  logic [HIST_AW-1:0]  hist_ptr = '0;
  logic [GSIZE_W-1:0]  gsize [NUM_GROUPS];
  logic [COEF_W-1:0]   coef [COEF_DEPTH];
  bit                  gsize_ok [NUM_GROUPS];  // entry written at least once
  bit                  coef_ok [COEF_DEPTH];
  logic [CFG_W-1:0]    group_count_q = GROUP_COUNT_RST;

  logic [OUT_W-1:0]    expected_filtered [$];
  logic [OUT_W-1:0]    filtered_want;
  int                  mismatch_count = 0;
  int                  burst_left = 0;

  initial begin
    foreach (history[i]) history[i] = '0;
    foreach (gsize[i]) gsize[i] = '0;
    foreach (coef[i]) coef[i] = '0;
  end

  // Applies one beat to the shadow state; returns 1 with the filter output
  // when the beat is an audio sample.
  function automatic bit predict_beat(input logic [1:0] req, input logic [8:0] idx,
                                      input logic [8:0] val, input logic [15:0] smp,
                                      output logic [OUT_W-1:0] filtered);
    logic signed [63:0] acc;
    logic signed [63:0] term;
    logic [HIST_AW-1:0] slot;
    logic [COEF_W-1:0]  word;
    int                 ng;
    int                 pos;
    int                 g;
    int                 k;
    filtered = '0;
    case (req)
      REQ_GROUP: begin
        // indexes past the group table are dropped
        if (idx < NUM_GROUPS) begin
          gsize[GIDX_W'(idx)]    = val[GSIZE_W-1:0];
          gsize_ok[GIDX_W'(idx)] = 1'b1;
        end
        return 1'b0;
      end
      REQ_COEF: begin
        if (idx < COEF_DEPTH) begin
          coef[CIDX_W'(idx)]    = val;
          coef_ok[CIDX_W'(idx)] = 1'b1;
        end
        return 1'b0;
      end
      REQ_SAMPLE: begin
        history[hist_ptr] = smp;
        ng  = (group_count_q > NUM_GROUPS) ? NUM_GROUPS : int'(group_count_q);
        acc = '0;
        pos = 0;
        for (g = 0; g < ng; g++) begin
          acc = acc >>> 1;  // halve ahead of every group
          for (k = 0; k < gsize[GIDX_W'(g)]; k++) begin
            // positions off the end of the table still count toward the group
            if (pos < COEF_DEPTH) begin
              word = coef[CIDX_W'(pos)];
              slot = hist_ptr - word[DELAY_W-1:0];
              term = {{48{history[slot][SAMPLE_W-1]}}, history[slot]} << SAMPLE_SHIFT;
              // full-width subtract, so -32768 negates cleanly
              acc  = word[SIGN_BIT] ? acc - term : acc + term;
            end
            pos++;
          end
        end
        acc      = acc >>> 1;
        hist_ptr = hist_ptr + 1'b1;
        filtered = acc[OUT_W-1:0];
        return 1'b1;
      end
      default: return 1'b0;  // request type three: no effect
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t ns: MISMATCH %s", $realtime, what);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Input side: bursts of beats separated by random gaps
  // ---------------------------------------------------------------------------
  task automatic send_beat(input logic [1:0] req, input logic [8:0] idx,
                           input logic [8:0] val, input logic [15:0] smp,
                           input bit typed = 1'b0, input logic [OUT_W-1:0] want = '0);
    int unsigned    gap;
    logic [OUT_W-1:0] predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(10, 60);
        default: gap = $urandom_range(1, 6);
      endcase
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, smp, val, idx};
    s_axis_tuser  <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    // beat taken at this edge
    if (predict_beat(req, idx, val, smp, predicted))
      expected_filtered = {expected_filtered, (typed ? want : predicted)};
  endtask

  // Loads any group size or coefficient the next sample would read that has
  // never been written, so no walk touches an undefined entry.
  task automatic prepare_tables();
    int ng;
    int total;
    int g;
    int p;
    ng    = (group_count_q > NUM_GROUPS) ? NUM_GROUPS : int'(group_count_q);
    total = 0;
    for (g = 0; g < ng; g++) begin
      if (!gsize_ok[GIDX_W'(g)])
        send_beat(REQ_GROUP, 9'(g), 9'($urandom_range(0, 12)), 16'($urandom));
      total += gsize[GIDX_W'(g)];
    end
    for (p = 0; p < total && p < COEF_DEPTH; p++)
      if (!coef_ok[CIDX_W'(p)]) send_beat(REQ_COEF, 9'(p), 9'($urandom), 16'($urandom));
  endtask

  task automatic send_sample(input logic [15:0] smp);
    prepare_tables();
    send_beat(REQ_SAMPLE, 9'($urandom), 9'($urandom), smp);
  endtask

  task automatic random_step();
    int unsigned pick;
    logic [15:0] smp;
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      case ($urandom_range(0, 9))
        0:       smp = 16'h8000;
        1:       smp = 16'h7FFF;
        default: smp = 16'($urandom);
      endcase
      send_sample(smp);
    end else if (pick < 75) begin
      // mostly the front of the table, where walks actually read
      send_beat(REQ_COEF, ($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(0, 63)),
                9'($urandom), 16'($urandom));
    end else if (pick < 88) begin
      send_beat(REQ_GROUP, 9'($urandom_range(0, NUM_GROUPS - 1)),
                {1'($urandom), 8'($urandom_range(0, 12))}, 16'($urandom));
    end else if (pick < 94) begin
      // group index past the table: dropped
      send_beat(REQ_GROUP, 9'($urandom_range(NUM_GROUPS, 511)), 9'($urandom), 16'($urandom));
    end else begin
      send_beat(REQ_NONE, 9'($urandom), 9'($urandom), 16'($urandom));
    end
  endtask

  // Config writes only with the block idle: no result owed, plus a short
  // hold-off for a table-write beat still in flight.
  task automatic write_group_count(input logic [CFG_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_filtered.size() != 0) @(posedge clk_i);
    repeat (CFG_HOLD) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i   <= 1'b0;
    group_count_q = value;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready pattern switching between free, choppy and long stalls
  // ---------------------------------------------------------------------------
  rx_mode_e rx_mode    = RX_FREE;
  int       mode_left  = 0;
  int       stall_left = 0;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      rx_mode   = rx_mode_e'($urandom_range(0, 2));
      mode_left = $urandom_range(100, 400);
    end
    mode_left--;
    if (stall_left == 0) begin
      case (rx_mode)
        RX_CHOPPY: if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 3);
        RX_LONG:   if ($urandom_range(0, 15) == 0) stall_left = $urandom_range(5, 20);
        default: ;
      endcase
    end
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result check against the oldest pending expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_filtered.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing pending: filtered %h",
                                  m_axis_tdata));
      end else begin
        filtered_want = expected_filtered.pop_front();
        if (m_axis_tdata !== filtered_want)
          report_mismatch($sformatf("filtered got %h want %h", m_axis_tdata, filtered_want));
      end
    end
  end

  // Watchdog on cycles with no beat on any channel
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog expired, %0d results pending", $realtime,
               expected_filtered.size());
      $display("power_of_two_term_fir_filter_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed rows, run with group_count = 2 (group 1 starts empty)
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [N_DIR] = '{
    '{REQ_GROUP,  9'd0,   9'd1,     16'h0000, 1'b0, 40'h0},
    '{REQ_GROUP,  9'd1,   9'd0,     16'h0000, 1'b0, 40'h0},  // empty group
    '{REQ_COEF,   9'd0,   9'h000,   16'h0000, 1'b0, 40'h0},
    // +max: 0x7FFF << 16, halved twice by group 1 and the final shift
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h7FFF, 1'b1, 40'h001FFFC000},
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h8000, 1'b1, 40'hFFE0000000},
    '{REQ_COEF,   9'd0,   9'h100,   16'h0000, 1'b0, 40'h0},
    // subtracting -32768 must come out positive at full width
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h8000, 1'b1, 40'h0020000000},
    '{REQ_COEF,   9'd0,   9'h1FF,   16'h0000, 1'b0, 40'h0},
    // delay 255 reaches a history slot never filled since reset
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h1234, 1'b1, 40'h0},
    '{REQ_GROUP,  9'd1,   9'd3,     16'h0000, 1'b0, 40'h0},
    '{REQ_COEF,   9'd1,   9'h001,   16'h0000, 1'b0, 40'h0},
    '{REQ_COEF,   9'd2,   9'h102,   16'h0000, 1'b0, 40'h0},
    '{REQ_COEF,   9'd3,   9'h0FF,   16'h0000, 1'b0, 40'h0},
    '{REQ_SAMPLE, 9'h1FF, 9'h1FF,   16'hFFFF, 1'b0, 40'h0},
    '{REQ_NONE,   9'h1FF, 9'h1FF,   16'hFFFF, 1'b0, 40'h0},  // ignored kind
    '{REQ_GROUP,  9'd16,  9'h0FF,   16'h0000, 1'b0, 40'h0},  // just past the table
    '{REQ_GROUP,  9'h1FF, 9'h1FF,   16'h0000, 1'b0, 40'h0},
    '{REQ_COEF,   9'h1FF, 9'h0AA,   16'h0000, 1'b0, 40'h0},  // last coefficient slot
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h0001, 1'b0, 40'h0},
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h8000, 1'b0, 40'h0},
    '{REQ_SAMPLE, 9'd0,   9'd0,     16'h7FFF, 1'b0, 40'h0}
  };

  // Group counts per random phase: extremes, zero and saturating values
  logic [CFG_W-1:0] phase_counts [6] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd17, 5'd8};

  initial begin
    int p;
    int g;
    int i;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_group_count(5'd2);
    for (i = 0; i < N_DIR; i++)
      send_beat(directed_rows[i].req, directed_rows[i].idx, directed_rows[i].val,
                directed_rows[i].smp, directed_rows[i].typed, directed_rows[i].want);

    for (p = 0; p < N_PHASE; p++) begin
      write_group_count((p < 6) ? phase_counts[p] : 5'($urandom));
      repeat (PHASE_ITEMS) random_step();
    end

    // Long walk: every group near full size, so the walk runs off the end of
    // the coefficient table. Kept last and short since each sample is slow.
    write_group_count(5'd31);
    for (g = 0; g < NUM_GROUPS; g++)
      send_beat(REQ_GROUP, 9'(g), (g == 0) ? 9'd255 : 9'($urandom_range(200, 255)),
                16'($urandom));
    repeat (3) send_sample(16'($urandom));

    s_axis_tvalid <= 1'b0;
    while (expected_filtered.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_filtered.size() == 0) begin
      $display("power_of_two_term_fir_filter_unit test passed");
    end else begin
      $display("power_of_two_term_fir_filter_unit test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/ptf_pkg.sv
hw/rtl/ptf_ram.sv
hw/rtl/power_of_two_term_fir_filter_unit.sv
tb/tb.sv
